// ===== sv/fseq_pkg.sv =====
// Shared types and constants for the frame sequencer.
// Holds the configuration, state, input word and result word types.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fseq_pkg;

  localparam int MaxFrames = 64;
  localparam int PosW      = 6;
  localparam int CntW      = PosW + 1;
  localparam int ModeW     = 3;
  localparam int CountW    = 7;
  localparam int DelayW    = 24;
  localparam int ElapsedW  = 16;
  localparam int SumW      = 32;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 24;

  localparam logic [CfgIdxW-1:0] RegPlayMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameCount = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLimitFrame = 2'd2;
  localparam logic [CfgIdxW-1:0] RegFrameDelay = 2'd3;

  localparam logic [ModeW-1:0] ModeLoop         = 3'd0;
  localparam logic [ModeW-1:0] ModeLoopToLimit  = 3'd1;
  localparam logic [ModeW-1:0] ModeOnceFromLim  = 3'd2;
  localparam logic [ModeW-1:0] ModeOnceToLimit  = 3'd3;
  localparam logic [ModeW-1:0] ModeLoopUpToLim  = 3'd4;
  localparam logic [ModeW-1:0] ModeOnce         = 3'd5;
  localparam logic [ModeW-1:0] ModePingPong     = 3'd6;
  localparam logic [ModeW-1:0] ModePingPongOnce = 3'd7;

  typedef enum logic [1:0] {
    CmdTick    = 2'd0,
    CmdRestart = 2'd1,
    CmdJump    = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [ModeW-1:0]  play_mode;
    logic [CountW-1:0] frame_count;
    logic [PosW-1:0]   limit_frame;
    logic [DelayW-1:0] frame_delay;
  } cfg_t;

  typedef struct packed {
    logic [SumW-1:0] time_sum;
    logic [PosW-1:0] frame_pos;
    logic            run_done;
    logic            reverse_dir;
  } state_t;

  typedef struct packed {
    cmd_e                command;
    logic [ElapsedW-1:0] elapsed_time;
    logic [PosW-1:0]     jump_frame;
  } in_t;

  typedef struct packed {
    logic [PosW-1:0] frame_index;
    logic            finished;
    logic            going_back;
  } out_t;

endpackage

`default_nettype wire

// ===== sv/fseq_step.sv =====
// Next-state logic of the frame sequencer: one word against the current state.
// Purely combinational; uses fseq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fseq_step (
  input  wire fseq_pkg::cfg_t   cfg_i,
  input  wire fseq_pkg::state_t state_i,
  input  wire fseq_pkg::in_t    item_i,
  output fseq_pkg::state_t      state_o,
  output fseq_pkg::out_t        result_o
);
  import fseq_pkg::*;

  logic [CntW-1:0]  n;
  logic [CntW-1:0]  n_m1;
  logic [CntW-1:0]  lim;
  logic [CntW-1:0]  pos0;
  logic [CntW-1:0]  p1;
  logic [CntW-1:0]  q;
  logic [CntW-1:0]  q1;
  logic [CntW-1:0]  pm;
  logic [CntW-1:0]  p;
  logic [SumW:0]    sum_full;
  logic [SumW-1:0]  sum_sat;
  logic             acc_en;
  logic             adv;
  logic             done_t;
  logic             rev_t;
  logic [SumW-1:0]  ts_t;
  state_t           nx;

  always_comb begin
    n = CntW'(cfg_i.frame_count);
    if (n == '0) begin
      n = CntW'(1);
    end else if (n > CntW'(MaxFrames)) begin
      n = CntW'(MaxFrames);
    end
    n_m1 = n - CntW'(1);
    lim  = CntW'(cfg_i.limit_frame);
    if (lim > n_m1) begin
      lim = n_m1;
    end
    pos0 = CntW'(state_i.frame_pos);
    if (pos0 >= n) begin
      pos0 = '0;
    end
    p1 = pos0 + CntW'(1);

    case (cfg_i.play_mode)
      ModeOnce:         acc_en = !state_i.run_done;
      ModePingPong:     acc_en = (n != CntW'(1));
      ModePingPongOnce: acc_en = (n != CntW'(1)) && !state_i.run_done;
      default:          acc_en = 1'b1;
    endcase

    sum_full = {1'b0, state_i.time_sum} + (SumW + 1)'(item_i.elapsed_time);
    sum_sat  = sum_full[SumW] ? '1 : sum_full[SumW-1:0];
    adv      = acc_en && (sum_sat > SumW'(cfg_i.frame_delay));

    ts_t   = state_i.time_sum;
    done_t = state_i.run_done;
    rev_t  = state_i.reverse_dir;
    p      = pos0;
    q      = pos0;
    q1     = p1;
    pm     = pos0;
    if (acc_en) begin
      ts_t = adv ? '0 : sum_sat;
    end

    case (cfg_i.play_mode)
      ModeLoop: begin
        if (adv) p = (p1 >= n) ? '0 : p1;
      end
      ModeLoopToLimit: begin
        if (adv) p = (p1 >= n) ? lim : p1;
      end
      ModeOnceFromLim: begin
        q  = (pos0 < lim) ? lim : pos0;
        q1 = q + CntW'(1);
        p  = q;
        if (adv) p = (q1 >= n) ? n_m1 : q1;
      end
      ModeOnceToLimit: begin
        q  = (pos0 > lim) ? lim : pos0;
        q1 = q + CntW'(1);
        p  = q;
        if (adv) p = (q1 > lim) ? lim : q1;
      end
      ModeLoopUpToLim: begin
        q  = (pos0 > lim) ? '0 : pos0;
        q1 = q + CntW'(1);
        p  = q;
        if (adv) p = (q1 > lim) ? '0 : q1;
      end
      ModeOnce: begin
        if (adv) begin
          if (p1 >= n) begin
            done_t = 1'b1;
            p      = n_m1;
          end else begin
            p = p1;
          end
        end
      end
      default: begin
        if (n == CntW'(1)) begin
          p = '0;
        end else if (adv) begin
          if (state_i.reverse_dir) begin
            pm = (pos0 > '0) ? pos0 - CntW'(1) : '0;
            p  = pm;
            if (pm == '0) begin
              if (cfg_i.play_mode == ModePingPongOnce) done_t = 1'b1;
              else rev_t = 1'b0;
            end
          end else if (p1 >= n) begin
            rev_t = 1'b1;
            p     = n_m1;
          end else begin
            p = p1;
          end
        end
      end
    endcase

    nx = state_i;
    case (item_i.command)
      CmdTick: begin
        nx.time_sum    = ts_t;
        nx.frame_pos   = p[PosW-1:0];
        nx.run_done    = done_t;
        nx.reverse_dir = rev_t;
      end
      CmdRestart: begin
        nx.frame_pos   = '0;
        nx.run_done    = 1'b0;
        nx.reverse_dir = 1'b0;
      end
      CmdJump: begin
        if (CntW'(item_i.jump_frame) < n) nx.frame_pos = item_i.jump_frame;
      end
      default: begin
        nx = state_i;
      end
    endcase
  end

  assign state_o              = nx;
  assign result_o.frame_index = nx.frame_pos;
  assign result_o.finished    = nx.run_done;
  assign result_o.going_back  = nx.reverse_dir;

endmodule

`default_nettype wire

// ===== sv/frame_sequencer_with_play_modes_core.sv =====
// Frame sequencer with eight play modes: top level.
// Input register, next-state logic (fseq_step) and result register; uses fseq_pkg.
//
// Usage:
//   Words enter on in_valid_i / in_ready_o: a tick with elapsed time, a restart
//   or a jump. Each word yields exactly one result word on out_valid_o /
//   out_ready_i carrying the frame index and the finished and going-back marks.
//   Registers are written through cfg_we_i, cfg_index_i and cfg_wdata_i; the
//   user must do so only while no word is in flight, which the block does not
//   enforce. A write takes effect at the next edge. An accepted word passes
//   through the input register and then the result register to out_valid_o.
//   Throughput: one word per cycle unless stalled; the state update is one
//   saturating 32-bit add, one frame-delay compare and a small index update.
//   Reset clears the accumulator, position and marks and loads play mode 0,
//   frame count 1, limit 0 and delay 0.
//   When the receiver stalls, the result register holds its word and the
//   input register holds one more; in_ready_o drops once both are full.
`timescale 1ns / 1ps
`default_nettype none

module frame_sequencer_with_play_modes_core (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [fseq_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire [fseq_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire fseq_pkg::in_t             in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output fseq_pkg::out_t                 out_data_o
);
  import fseq_pkg::*;

  cfg_t   cfg_q;
  state_t state_q;
  state_t state_d;
  in_t    in_q;
  logic   in_valid_q;
  out_t   out_q;
  out_t   out_d;
  logic   out_valid_q;
  logic   advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.play_mode   <= ModeLoop;
      cfg_q.frame_count <= CountW'(1);
      cfg_q.limit_frame <= '0;
      cfg_q.frame_delay <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegPlayMode:   cfg_q.play_mode   <= cfg_wdata_i[ModeW-1:0];
        RegFrameCount: cfg_q.frame_count <= cfg_wdata_i[CountW-1:0];
        RegLimitFrame: cfg_q.limit_frame <= cfg_wdata_i[PosW-1:0];
        RegFrameDelay: cfg_q.frame_delay <= cfg_wdata_i[DelayW-1:0];
        default:       cfg_q             <= cfg_q;
      endcase
    end
  end

  fseq_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_data_i;
    if (advance) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_q)))
    else $error("input word dropped while result side stalled");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_q && out_q.frame_index == state_q.frame_pos))
    else $error("processed word did not reach the result register");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.command == CmdRestart) |=>
      (state_q.frame_pos == '0 && !state_q.run_done && !state_q.reverse_dir))
    else $error("restart did not clear position and marks");

endmodule

`default_nettype wire

// ===== tb/frame_sequencer_with_play_modes_core_checker.sv =====
// Result checker for the frame sequencer: tracks register writes, computes the
// frame word each accepted input word must produce and compares the results.
// Depends on fseq_pkg.
`timescale 1ns / 1ps

module frame_sequencer_with_play_modes_core_checker (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [fseq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [fseq_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire                          in_valid_i,
  input  wire                          in_ready_i,
  input  fseq_pkg::in_t                in_data_i,
  input  wire                          out_valid_i,
  input  wire                          out_ready_i,
  input  fseq_pkg::out_t               out_data_i,
  output int                           mismatch_count_o,
  output int                           pending_o
);
  import fseq_pkg::*;

  localparam int WantDepth = 256;

  logic [ModeW-1:0]  mode_q;
  logic [CountW-1:0] count_q;
  logic [PosW-1:0]   limit_q;
  logic [DelayW-1:0] delay_q;
  logic [SumW-1:0]   sum_q;
  logic [PosW-1:0]   pos_q;
  logic              done_q;
  logic              back_q;

  out_t want_mem [WantDepth];
  int   wr_ptr;
  int   rd_ptr;
  out_t want;

  function automatic bit add_time(input logic [ElapsedW-1:0] elapsed);
    logic [SumW:0] s;
    s = {1'b0, sum_q} + (SumW + 1)'(elapsed);
    sum_q = s[SumW] ? '1 : s[SumW-1:0];
    if (sum_q > delay_q) begin
      sum_q = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_t advance_frames(input in_t w);
    logic [CntW-1:0] n;
    logic [CntW-1:0] lim;
    logic [CntW-1:0] p;
    bit              due;
    bit              once;
    out_t            r;
    n = (count_q == 0) ? CntW'(1) : (count_q > MaxFrames) ? CntW'(MaxFrames) : count_q;
    case (w.command)
      CmdTick: begin
        lim = {1'b0, limit_q};
        if (lim > n - CntW'(1)) lim = n - CntW'(1);
        if ({1'b0, pos_q} >= n) pos_q = '0;
        p = {1'b0, pos_q};
        case (mode_q)
          ModeLoop: begin
            if (add_time(w.elapsed_time)) begin
              p++;
              if (p >= n) p = '0;
            end
          end
          ModeLoopToLimit: begin
            if (add_time(w.elapsed_time)) begin
              p++;
              if (p >= n) p = lim;
            end
          end
          ModeOnceFromLim: begin
            due = add_time(w.elapsed_time);
            if (p < lim) p = lim;
            if (due) begin
              p++;
              if (p >= n) p = n - CntW'(1);
            end
          end
          ModeOnceToLimit: begin
            due = add_time(w.elapsed_time);
            if (p > lim) p = lim;
            if (due) begin
              p++;
              if (p > lim) p = lim;
            end
          end
          ModeLoopUpToLim: begin
            due = add_time(w.elapsed_time);
            if (p > lim) p = '0;
            if (due) begin
              p++;
              if (p > lim) p = '0;
            end
          end
          ModeOnce: begin
            if (!done_q) begin
              if (add_time(w.elapsed_time)) begin
                p++;
                if (p >= n) begin
                  done_q = 1'b1;
                  p = n - CntW'(1);
                end
              end
            end
          end
          default: begin
            once = (mode_q == ModePingPongOnce);
            if (n == 1) begin
              p = '0;
            end else if (!(once && done_q)) begin
              if (add_time(w.elapsed_time)) begin
                if (back_q) begin
                  if (p > 0) p--;
                  if (p == 0) begin
                    if (once) done_q = 1'b1;
                    else back_q = 1'b0;
                  end
                end else begin
                  p++;
                  if (p >= n) begin
                    back_q = 1'b1;
                    p = n - CntW'(1);
                  end
                end
              end
            end
          end
        endcase
        pos_q = p[PosW-1:0];
      end
      CmdRestart: begin
        done_q = 1'b0;
        back_q = 1'b0;
        pos_q  = '0;
      end
      CmdJump: begin
        if ({1'b0, w.jump_frame} < n) pos_q = w.jump_frame;
      end
      default: ;
    endcase
    r.frame_index = pos_q;
    r.finished    = done_q;
    r.going_back  = back_q;
    return r;
  endfunction

  task automatic stash_word(input out_t w);
    want_mem[wr_ptr % WantDepth] = w;
    wr_ptr++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  = ModeLoop;
      count_q = CountW'(1);
      limit_q = '0;
      delay_q = '0;
      sum_q   = '0;
      pos_q   = '0;
      done_q  = 1'b0;
      back_q  = 1'b0;
      wr_ptr  = 0;
      rd_ptr  = 0;
      pending_o        = 0;
      mismatch_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegPlayMode:   mode_q  = cfg_wdata_i[ModeW-1:0];
          RegFrameCount: count_q = cfg_wdata_i[CountW-1:0];
          RegLimitFrame: limit_q = cfg_wdata_i[PosW-1:0];
          RegFrameDelay: delay_q = cfg_wdata_i[DelayW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (wr_ptr == rd_ptr) begin
          $display("%0t: unexpected result word: index %0d finished %0b back %0b",
                   $time, out_data_i.frame_index, out_data_i.finished,
                   out_data_i.going_back);
          mismatch_count_o++;
        end else begin
          want = want_mem[rd_ptr % WantDepth];
          rd_ptr++;
          if (out_data_i.frame_index !== want.frame_index ||
              out_data_i.finished !== want.finished ||
              out_data_i.going_back !== want.going_back) begin
            $display("%0t: expected idx %0d fin %0b back %0b, got idx %0d fin %0b back %0b",
                     $time, want.frame_index, want.finished, want.going_back,
                     out_data_i.frame_index, out_data_i.finished,
                     out_data_i.going_back);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) stash_word(advance_frames(in_data_i));
      pending_o = wr_ptr - rd_ptr;
    end
  end

endmodule

// ===== tb/frame_sequencer_with_play_modes_core_tb.sv =====
// Top of the frame sequencer testbench: clock, reset, register writes and word
// stimulus with random idling; verdict from the checker's count.
// Depends on fseq_pkg, frame_sequencer_with_play_modes_core and its checker.
`timescale 1ns / 1ps

module frame_sequencer_with_play_modes_core_tb;
  import fseq_pkg::*;

  localparam logic [1:0] CmdUnused   = 2'd3;
  localparam int         RandomItems = 650;
  localparam int         CalmTail    = 80;
  localparam int         QuietLimit  = 2000;
  localparam int         LongHold    = 64;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_t                out_data_o;

  int mismatches;
  int pending;
  int quiet_cycles;
  int rx_hold_req;
  bit rx_idle_en;
  bit tx_idle_en;

  frame_sequencer_with_play_modes_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  frame_sequencer_with_play_modes_core_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("frame_sequencer_with_play_modes_core: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, run-through stretches, and one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req != 0) begin
        n = rx_hold_req;
        rx_hold_req = 0;
        out_ready_i <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        if (rx_idle_en) repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end
    end
  end

  function automatic in_t make_word(input logic [1:0] cmd, input logic [ElapsedW-1:0] elapsed,
                                    input logic [PosW-1:0] jump);
    in_t w;
    w.command      = cmd_e'(cmd);
    w.elapsed_time = elapsed;
    w.jump_frame   = jump;
    return w;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input in_t w);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic load_config(input logic [ModeW-1:0] mode, input logic [CountW-1:0] count,
                             input logic [PosW-1:0] lim, input logic [DelayW-1:0] delay);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegPlayMode;
    cfg_wdata_i <= CfgDataW'(mode);
    @(negedge clk_i);
    cfg_index_i <= RegFrameCount;
    cfg_wdata_i <= CfgDataW'(count);
    @(negedge clk_i);
    cfg_index_i <= RegLimitFrame;
    cfg_wdata_i <= CfgDataW'(lim);
    @(negedge clk_i);
    cfg_index_i <= RegFrameDelay;
    cfg_wdata_i <= CfgDataW'(delay);
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
  endtask

  initial begin
    int sent;
    int phase;
    int len;
    int eff;
    int r;
    logic [ModeW-1:0]    mode;
    logic [CountW-1:0]   count;
    logic [PosW-1:0]     lim;
    logic [DelayW-1:0]   delay;
    logic [1:0]          cmd;
    logic [ElapsedW-1:0] elapsed;
    logic [PosW-1:0]     jump;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = RegPlayMode;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    rx_hold_req = 0;
    rx_idle_en  = 1'b1;
    tx_idle_en  = 1'b1;
    quiet_cycles = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: single frame, zero delay
    send_word(make_word(CmdTick, 16'd0, 6'd0));
    send_word(make_word(CmdTick, 16'hFFFF, 6'd0));
    send_word(make_word(CmdRestart, 16'h1234, 6'd0));
    send_word(make_word(CmdJump, 16'd0, 6'd63));
    send_word(make_word(CmdJump, 16'd0, 6'd0));
    send_word(make_word(CmdUnused, 16'hFFFF, 6'd63));

    // ping-pong over three frames, turn at both ends
    settle();
    load_config(ModePingPong, 7'd3, 6'd0, 24'd0);
    repeat (5) send_word(make_word(CmdTick, 16'd1, 6'd0));
    send_word(make_word(CmdJump, 16'd0, 6'd63));
    send_word(make_word(CmdJump, 16'd0, 6'd2));

    // ping-pong once over two frames: stale position, end mark, ignored tick
    settle();
    load_config(ModePingPongOnce, 7'd2, 6'd63, 24'd0);
    repeat (4) send_word(make_word(CmdTick, 16'd1, 6'd0));

    // zero frame count acts as single frame
    settle();
    load_config(ModePingPongOnce, 7'd0, 6'd0, 24'd0);
    send_word(make_word(CmdTick, 16'hFFFF, 6'd0));

    // lowered count leaves a stale position
    settle();
    load_config(ModeLoop, 7'd64, 6'd0, 24'd0);
    send_word(make_word(CmdJump, 16'd0, 6'd63));
    settle();
    load_config(ModeLoop, 7'd2, 6'd0, 24'd0);
    send_word(make_word(CmdTick, 16'd0, 6'd0));

    // play once to the end, then hold
    settle();
    load_config(ModeOnce, 7'd1, 6'd0, 24'd0);
    send_word(make_word(CmdTick, 16'd1, 6'd0));
    send_word(make_word(CmdTick, 16'd1, 6'd0));

    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      settle();
      rx_idle_en = (sent < RandomItems - CalmTail);
      tx_idle_en = rx_idle_en && (phase != 2);
      mode = ModeW'($urandom_range(0, 7));
      case ($urandom_range(0, 7))
        0: count = CountW'($urandom_range(0, 1));
        1: count = CountW'(MaxFrames);
        2: count = CountW'($urandom_range(65, 127));
        default: count = CountW'($urandom_range(2, 12));
      endcase
      eff = (count == 0) ? 1 : (count > MaxFrames) ? MaxFrames : int'(count);
      case ($urandom_range(0, 5))
        0: lim = '0;
        1: lim = 6'd63;
        default: lim = PosW'($urandom_range(0, eff - 1));
      endcase
      case ($urandom_range(0, 7))
        0: delay = '0;
        1: delay = 24'hFFFFFF;
        2: delay = DelayW'($urandom_range(0, 200));
        3: delay = DelayW'($urandom_range(0, 70000));
        default: delay = DelayW'($urandom_range(0, 20));
      endcase
      load_config(mode, count, lim, delay);
      if (phase == 2) begin
        rx_hold_req = LongHold;
        while (rx_hold_req != 0) @(negedge clk_i);
      end
      len = $urandom_range(15, 50);
      repeat (len) begin
        r       = $urandom_range(0, 99);
        elapsed = '0;
        jump    = PosW'($urandom_range(0, 63));
        case ($urandom_range(0, 5))
          0: elapsed = '0;
          1: elapsed = 16'hFFFF;
          2: elapsed = ElapsedW'($urandom_range(0, 65535));
          default: elapsed = ElapsedW'($urandom_range(0, 40));
        endcase
        if (r < 80) begin
          cmd = CmdTick;
        end else if (r < 88) begin
          cmd = CmdRestart;
        end else if (r < 97) begin
          cmd = CmdJump;
          if ($urandom_range(0, 1) == 0) jump = PosW'($urandom_range(0, eff - 1));
        end else begin
          cmd = CmdUnused;
        end
        send_word(make_word(cmd, elapsed, jump));
        sent++;
      end
      phase++;
    end

    settle();
    repeat (3) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("frame_sequencer_with_play_modes_core: match");
    end else begin
      $display("frame_sequencer_with_play_modes_core: mismatch");
    end
    $finish;
  end

endmodule
